@@ src/sme_pkg.sv @@
// Package: opcodes, status codes, stack effect tables and the result record.
`default_nettype none
package sme_pkg;

    localparam int STACK_DEPTH_DEF  = 64;
    localparam int MEMORY_BYTES_DEF = 4096;
    localparam int ADDRESS_BITS_DEF = 16;

    localparam int OP_W     = 5;
    localparam int WORD_W   = 64;
    localparam int STATUS_W = 3;
    localparam int NEXT_W   = 16;
    localparam int WCH_W    = 2;
    localparam int WADDR_W  = 12;
    localparam int WCNT_W   = 13;

    localparam logic [OP_W-1:0] OP_PUSH  = 5'd0;
    localparam logic [OP_W-1:0] OP_PLUS  = 5'd1;
    localparam logic [OP_W-1:0] OP_MINUS = 5'd2;
    localparam logic [OP_W-1:0] OP_EQ    = 5'd3;
    localparam logic [OP_W-1:0] OP_DUMP  = 5'd4;
    localparam logic [OP_W-1:0] OP_DUP   = 5'd5;
    localparam logic [OP_W-1:0] OP_GT    = 5'd6;
    localparam logic [OP_W-1:0] OP_LT    = 5'd7;
    localparam logic [OP_W-1:0] OP_IF    = 5'd8;
    localparam logic [OP_W-1:0] OP_ELSE  = 5'd9;
    localparam logic [OP_W-1:0] OP_WHILE = 5'd10;
    localparam logic [OP_W-1:0] OP_DO    = 5'd11;
    localparam logic [OP_W-1:0] OP_END   = 5'd12;
    localparam logic [OP_W-1:0] OP_MEM   = 5'd13;
    localparam logic [OP_W-1:0] OP_LOAD  = 5'd14;
    localparam logic [OP_W-1:0] OP_STORE = 5'd15;
    localparam logic [OP_W-1:0] OP_SYS1  = 5'd16;
    localparam logic [OP_W-1:0] OP_SYS3  = 5'd17;
    localparam logic [OP_W-1:0] OP_DUP2  = 5'd18;
    localparam logic [OP_W-1:0] OP_DROP  = 5'd19;
    localparam logic [OP_W-1:0] OP_SHR   = 5'd20;
    localparam logic [OP_W-1:0] OP_SHL   = 5'd21;
    localparam logic [OP_W-1:0] OP_BOR   = 5'd22;
    localparam logic [OP_W-1:0] OP_BAND  = 5'd23;
    localparam logic [OP_W-1:0] OP_SWAP  = 5'd24;
    localparam logic [OP_W-1:0] OP_OVER  = 5'd25;
    localparam logic [OP_W-1:0] OP_LAST  = OP_OVER;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_ADDR  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_SYS   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_FD    = 3'd5;
    localparam logic [STATUS_W-1:0] ST_BAD_OP    = 3'd6;

    localparam logic [WORD_W-1:0] SYS_WRITE = 64'd1;
    localparam logic [WORD_W-1:0] FD_STDOUT = 64'd1;
    localparam logic [WORD_W-1:0] FD_STDERR = 64'd2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [NEXT_W-1:0]   next_address;
        logic                print_valid;
        logic [WORD_W-1:0]   print_value;
        logic                write_valid;
        logic [WCH_W-1:0]    write_channel;
        logic [WADDR_W-1:0]  write_address;
        logic [WCNT_W-1:0]   write_count;
    } t_result;

    function automatic logic [2:0] pops_of(input logic [OP_W-1:0] op);
        logic [2:0] n;
        case (op)
            OP_DUMP, OP_DUP, OP_IF, OP_DO, OP_LOAD, OP_DROP: n = 3'd1;
            OP_PLUS, OP_MINUS, OP_EQ, OP_GT, OP_LT, OP_STORE, OP_DUP2,
            OP_SHR, OP_SHL, OP_BOR, OP_BAND, OP_SWAP, OP_OVER: n = 3'd2;
            OP_SYS3: n = 3'd4;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [2:0] pushes_of(input logic [OP_W-1:0] op);
        logic [2:0] n;
        case (op)
            OP_PUSH, OP_PLUS, OP_MINUS, OP_EQ, OP_GT, OP_LT, OP_MEM, OP_LOAD,
            OP_SHR, OP_SHL, OP_BOR, OP_BAND: n = 3'd1;
            OP_DUP, OP_SWAP: n = 3'd2;
            OP_OVER: n = 3'd3;
            OP_DUP2: n = 3'd4;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

@@ src/sme_alu.sv @@
// Instruction datapath: operand checks, arithmetic, jumps and the result record.
`default_nettype none
module sme_alu #(
    parameter int ADDRESS_BITS = sme_pkg::ADDRESS_BITS_DEF,
    parameter int MEMORY_BYTES = sme_pkg::MEMORY_BYTES_DEF
) (
    input  wire logic [sme_pkg::OP_W-1:0]     i_op,
    input  wire logic [sme_pkg::WORD_W-1:0]   i_operand,
    input  wire logic [ADDRESS_BITS-1:0]      i_ip,
    input  wire logic [sme_pkg::STATUS_W-1:0] i_fault,
    input  wire logic [sme_pkg::WORD_W-1:0]   i_p0,
    input  wire logic [sme_pkg::WORD_W-1:0]   i_p1,
    input  wire logic [sme_pkg::WORD_W-1:0]   i_p2,
    input  wire logic [sme_pkg::WORD_W-1:0]   i_p3,
    output sme_pkg::t_result                  o_res,
    output logic [ADDRESS_BITS-1:0]           o_next_ip,
    output logic                              o_ok,
    output logic [sme_pkg::WORD_W-1:0]        o_r0,
    output logic [sme_pkg::WORD_W-1:0]        o_r1,
    output logic [sme_pkg::WORD_W-1:0]        o_r2,
    output logic [sme_pkg::WORD_W-1:0]        o_r3
);

    localparam logic [sme_pkg::WORD_W-1:0] MEM_LIMIT = 64'(MEMORY_BYTES);

    logic [sme_pkg::STATUS_W-1:0] status;
    logic [ADDRESS_BITS-1:0]      next;
    logic [ADDRESS_BITS-1:0]      target;
    logic                         pv;
    logic [sme_pkg::WORD_W-1:0]   pval;
    logic                         wv;

    assign target = i_operand[ADDRESS_BITS-1:0];

    always_comb begin
        status = i_fault;
        next   = i_ip + ADDRESS_BITS'(1);
        pv     = 1'b0;
        pval   = '0;
        wv     = 1'b0;
        o_r0   = '0;
        o_r1   = '0;
        o_r2   = '0;
        o_r3   = '0;
        if (status == sme_pkg::ST_OK) begin
            case (i_op)
                sme_pkg::OP_PUSH:  o_r0 = i_operand;
                sme_pkg::OP_PLUS:  o_r0 = i_p1 + i_p0;
                sme_pkg::OP_MINUS: o_r0 = i_p1 - i_p0;
                sme_pkg::OP_EQ:    o_r0 = {63'd0, i_p1 == i_p0};
                sme_pkg::OP_DUMP: begin
                    pv   = 1'b1;
                    pval = i_p0;
                end
                sme_pkg::OP_DUP: begin
                    o_r0 = i_p0;
                    o_r1 = i_p0;
                end
                sme_pkg::OP_GT: o_r0 = {63'd0, $signed(i_p1) > $signed(i_p0)};
                sme_pkg::OP_LT: o_r0 = {63'd0, $signed(i_p1) < $signed(i_p0)};
                sme_pkg::OP_IF, sme_pkg::OP_DO: begin
                    if (i_p0 == '0) begin
                        next = target;
                    end
                end
                sme_pkg::OP_ELSE, sme_pkg::OP_END: next = target;
                sme_pkg::OP_LOAD: begin
                    if (i_p0 >= MEM_LIMIT) begin
                        status = sme_pkg::ST_BAD_ADDR;
                    end
                end
                sme_pkg::OP_STORE: begin
                    if (i_p1 >= MEM_LIMIT) begin
                        status = sme_pkg::ST_BAD_ADDR;
                    end
                end
                sme_pkg::OP_SYS1: status = sme_pkg::ST_BAD_SYS;
                sme_pkg::OP_SYS3: begin
                    if (i_p0 != sme_pkg::SYS_WRITE) begin
                        status = sme_pkg::ST_BAD_SYS;
                    end else if (i_p1 != sme_pkg::FD_STDOUT && i_p1 != sme_pkg::FD_STDERR) begin
                        status = sme_pkg::ST_BAD_FD;
                    end else if (i_p2 >= MEM_LIMIT || i_p3 > MEM_LIMIT - i_p2) begin
                        status = sme_pkg::ST_BAD_ADDR;
                    end else begin
                        wv = 1'b1;
                    end
                end
                sme_pkg::OP_DUP2: begin
                    o_r0 = i_p1;
                    o_r1 = i_p0;
                    o_r2 = i_p1;
                    o_r3 = i_p0;
                end
                sme_pkg::OP_SHR:  o_r0 = $signed(i_p1) >>> i_p0[5:0];
                sme_pkg::OP_SHL:  o_r0 = i_p1 << i_p0[5:0];
                sme_pkg::OP_BOR:  o_r0 = i_p1 | i_p0;
                sme_pkg::OP_BAND: o_r0 = i_p1 & i_p0;
                sme_pkg::OP_SWAP: begin
                    o_r0 = i_p0;
                    o_r1 = i_p1;
                end
                sme_pkg::OP_OVER: begin
                    o_r0 = i_p1;
                    o_r1 = i_p0;
                    o_r2 = i_p1;
                end
                default: ; // while, mem, drop: nothing to compute
            endcase
        end
    end

    assign o_ok      = (status == sme_pkg::ST_OK);
    assign o_next_ip = next;

    always_comb begin
        o_res               = '0;
        o_res.status        = status;
        o_res.next_address  = o_ok ? sme_pkg::NEXT_W'(next) : sme_pkg::NEXT_W'(i_ip);
        if (o_ok) begin
            o_res.print_valid   = pv;
            o_res.print_value   = pval;
            o_res.write_valid   = wv;
            o_res.write_channel = wv ? i_p1[sme_pkg::WCH_W-1:0] : '0;
            o_res.write_address = wv ? i_p2[sme_pkg::WADDR_W-1:0] : '0;
            o_res.write_count   = wv ? i_p3[sme_pkg::WCNT_W-1:0] : '0;
        end
    end

endmodule
`default_nettype wire

@@ src/stack_machine_execute_unit.sv @@
// Top level: stack machine execute unit with stack and byte memories.
//
// channel  dir  handshake                  payload
// in       in   i_in_valid / o_in_stall    i_action, i_operand
// out      out  o_out_valid / i_out_stall  o_status, o_next_address, o_print_*, o_write_*
//
// Most instructions run a stack read, then execute and write back the top.
// sys3 adds the S_RD state for its second pair of stack reads; load adds S_LD for the byte
// memory read; each push beyond the first adds an S_WR step on the single stack write port.
// After reset a clearing pass zeroes the byte memory.
// A result waits in the output register; the next instruction runs meanwhile
// and only stalls when its own result finds that register still full.
`default_nettype none
module stack_machine_execute_unit #(
    parameter int STACK_DEPTH  = sme_pkg::STACK_DEPTH_DEF,
    parameter int MEMORY_BYTES = sme_pkg::MEMORY_BYTES_DEF,
    parameter int ADDRESS_BITS = sme_pkg::ADDRESS_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [sme_pkg::OP_W-1:0]           i_action,
    input  wire logic signed [sme_pkg::WORD_W-1:0]  i_operand,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [sme_pkg::STATUS_W-1:0]            o_status,
    output logic [sme_pkg::NEXT_W-1:0]              o_next_address,
    output logic                                    o_print_valid,
    output logic signed [sme_pkg::WORD_W-1:0]       o_print_value,
    output logic                                    o_write_valid,
    output logic [sme_pkg::WCH_W-1:0]               o_write_channel,
    output logic [sme_pkg::WADDR_W-1:0]             o_write_address,
    output logic [sme_pkg::WCNT_W-1:0]              o_write_count
);

    localparam int SW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int MW = $clog2(MEMORY_BYTES);

    typedef enum logic [6:0] {
        S_CLR  = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_RD   = 7'b0000100,
        S_EXEC = 7'b0001000,
        S_WR   = 7'b0010000,
        S_LD   = 7'b0100000,
        S_PUB  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [sme_pkg::WORD_W-1:0] r_stk [STACK_DEPTH];
    logic [sme_pkg::WORD_W-1:0] r_q0, r_q1;
    logic [7:0]                 r_mem [MEMORY_BYTES];
    logic [7:0]                 r_bq;

    logic [MW-1:0]                r_clr_cnt;
    logic [DW-1:0]                r_depth, r_nd;
    logic [ADDRESS_BITS-1:0]      r_ip;
    logic [sme_pkg::OP_W-1:0]     r_op;
    logic [sme_pkg::WORD_W-1:0]   r_operand;
    logic [sme_pkg::STATUS_W-1:0] r_fault;
    logic [2:0]                   r_nr;
    logic [SW-1:0]                r_base;
    logic [1:0]                   r_wk;
    logic [sme_pkg::WORD_W-1:0]   r_p0, r_p1;
    logic [sme_pkg::WORD_W-1:0]   r_rv [4];
    sme_pkg::t_result             r_hold, r_out;
    logic                         r_ov;

    logic                         in_acc;
    logic [2:0]                   np, nr;
    logic [DW:0]                  nd;
    logic [sme_pkg::STATUS_W-1:0] fault;
    logic [SW-1:0]                ra0, ra1;
    logic                         st_we;
    logic [SW-1:0]                st_wa;
    logic [sme_pkg::WORD_W-1:0]   st_wd;
    logic                         b_we;
    logic [MW-1:0]                b_wa;
    logic [7:0]                   b_wd;
    logic                         slot_free;
    logic                         pub;
    sme_pkg::t_result             pub_val;
    logic                         last_wr;

    logic [sme_pkg::WORD_W-1:0]   a_p0, a_p1;
    sme_pkg::t_result             a_res;
    logic [ADDRESS_BITS-1:0]      a_next;
    logic                         a_ok;
    logic [sme_pkg::WORD_W-1:0]   a_r0, a_r1, a_r2, a_r3;

    assign in_acc    = (r_state == S_IDLE) && i_in_valid;
    assign slot_free = !r_ov || !i_out_stall;
    assign last_wr   = ({1'b0, r_wk} == r_nr - 3'd1);

    // stack effect checks, done at accept time from the depth register
    always_comb begin
        np = sme_pkg::pops_of(i_action);
        nr = sme_pkg::pushes_of(i_action);
        nd = (DW+1)'(r_depth) - (DW+1)'(np) + (DW+1)'(nr);
        if (i_action > sme_pkg::OP_LAST) begin
            fault = sme_pkg::ST_BAD_OP;
        end else if (r_depth < DW'(np)) begin
            fault = sme_pkg::ST_UNDERFLOW;
        end else if (nd > (DW+1)'(STACK_DEPTH)) begin
            fault = sme_pkg::ST_OVERFLOW;
        end else begin
            fault = sme_pkg::ST_OK;
        end
    end

    // top two on accept, next two in the S_RD read state of sys3
    always_comb begin
        if (r_state == S_RD) begin
            ra0 = SW'(r_depth - DW'(3));
            ra1 = SW'(r_depth - DW'(4));
        end else begin
            ra0 = SW'(r_depth - DW'(1));
            ra1 = SW'(r_depth - DW'(2));
        end
    end

    assign a_p0 = (r_op == sme_pkg::OP_SYS3) ? r_p0 : r_q0;
    assign a_p1 = (r_op == sme_pkg::OP_SYS3) ? r_p1 : r_q1;

    sme_alu #(
        .ADDRESS_BITS (ADDRESS_BITS),
        .MEMORY_BYTES (MEMORY_BYTES)
    ) u_alu (
        .i_op      (r_op),
        .i_operand (r_operand),
        .i_ip      (r_ip),
        .i_fault   (r_fault),
        .i_p0      (a_p0),
        .i_p1      (a_p1),
        .i_p2      (r_q0),
        .i_p3      (r_q1),
        .o_res     (a_res),
        .o_next_ip (a_next),
        .o_ok      (a_ok),
        .o_r0      (a_r0),
        .o_r1      (a_r1),
        .o_r2      (a_r2),
        .o_r3      (a_r3)
    );

    always_comb begin
        n_state = r_state;
        pub     = 1'b0;
        pub_val = r_hold;
        st_we   = 1'b0;
        st_wa   = r_base;
        st_wd   = a_r0;
        b_we    = 1'b0;
        b_wa    = r_clr_cnt;
        b_wd    = '0;
        case (r_state)
            S_CLR: begin
                b_we = 1'b1;
                if (r_clr_cnt == MW'(MEMORY_BYTES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (fault == sme_pkg::ST_OK && i_action == sme_pkg::OP_SYS3)
                            ? S_RD : S_EXEC;
                end
            end
            S_RD: n_state = S_EXEC;
            S_EXEC: begin
                if (a_ok && r_op == sme_pkg::OP_STORE) begin
                    b_we = 1'b1;
                    b_wa = a_p1[MW-1:0];
                    b_wd = a_p0[7:0];
                end
                if (a_ok && r_op != sme_pkg::OP_LOAD && r_nr != 3'd0) begin
                    st_we = 1'b1;
                end
                if (a_ok && r_op == sme_pkg::OP_LOAD) begin
                    n_state = S_LD;
                end else if (a_ok && r_nr > 3'd1) begin
                    n_state = S_WR;
                end else if (slot_free) begin
                    pub     = 1'b1;
                    pub_val = a_res;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_PUB;
                end
            end
            S_WR: begin
                st_we = 1'b1;
                st_wa = r_base + SW'(r_wk);
                st_wd = r_rv[r_wk];
                if (last_wr) begin
                    if (slot_free) begin
                        pub     = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_PUB;
                    end
                end
            end
            S_LD: begin
                st_we = 1'b1;
                st_wd = {56'd0, r_bq};
                if (slot_free) begin
                    pub     = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_PUB;
                end
            end
            S_PUB: begin
                if (slot_free) begin
                    pub     = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // stack memory: two read ports, one write port
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_stk[st_wa] <= st_wd;
        end
        r_q0 <= r_stk[ra0];
        r_q1 <= r_stk[ra1];
    end

    // byte memory: one write and one read per cycle
    always_ff @(posedge i_clk) begin
        if (b_we) begin
            r_mem[b_wa] <= b_wd;
        end
        r_bq <= r_mem[a_p0[MW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr_cnt <= '0;
            r_depth   <= '0;
            r_ip      <= '0;
            r_ov      <= 1'b0;
            r_op      <= '0;
            r_fault   <= '0;
            r_nr      <= '0;
            r_wk      <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr_cnt <= r_clr_cnt + MW'(1);
            end
            if (in_acc) begin
                r_op    <= i_action;
                r_fault <= fault;
                r_nr    <= (fault == sme_pkg::ST_OK) ? nr : 3'd0;
            end
            if (r_state == S_EXEC) begin
                r_wk <= 2'd1;
                if (a_ok) begin
                    r_depth <= r_nd;
                    r_ip    <= a_next;
                end
            end else if (r_state == S_WR) begin
                r_wk <= r_wk + 2'd1;
            end
            if (pub) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_operand <= i_operand;
            r_nd      <= nd[DW-1:0];
            r_base    <= SW'(r_depth - DW'(np));
        end
        if (r_state == S_RD) begin
            r_p0 <= r_q0;
            r_p1 <= r_q1;
        end
        if (r_state == S_EXEC) begin
            r_hold   <= a_res;
            r_rv[0]  <= a_r0;
            r_rv[1]  <= a_r1;
            r_rv[2]  <= a_r2;
            r_rv[3]  <= a_r3;
        end
        if (pub) begin
            r_out <= pub_val;
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_ov;
    assign o_status        = r_out.status;
    assign o_next_address  = r_out.next_address;
    assign o_print_valid   = r_out.print_valid;
    assign o_print_value   = $signed(r_out.print_value);
    assign o_write_valid   = r_out.write_valid;
    assign o_write_channel = r_out.write_channel;
    assign o_write_address = r_out.write_address;
    assign o_write_count   = r_out.write_count;

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(STACK_DEPTH))
        else $error("stack depth above capacity");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pub |-> slot_free)
        else $error("pending result overwritten");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLR |-> r_depth == '0 && !r_ov)
        else $error("activity during memory clearing");

    a_pub_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pub |-> r_state != S_IDLE && r_state != S_CLR && r_state != S_RD)
        else $error("result published outside an instruction");

endmodule
`default_nettype wire

@@ sim/stack_machine_execute_unit_test.sv @@
// Testbench for the stack machine execute unit: directed and random instructions, scoreboarded.
`timescale 1ns / 1ps
module stack_machine_execute_unit_test;

    localparam int DEPTH = sme_pkg::STACK_DEPTH_DEF;
    localparam int MEM_BYTES = sme_pkg::MEMORY_BYTES_DEF;
    localparam logic [sme_pkg::OP_W-1:0] OP_UNDEF = 5'd31;
    localparam int HOLD_CYCLES = 300;

    class exec_scoreboard;
        logic [63:0] stk [DEPTH];
        int depth;
        logic [7:0] mem [MEM_BYTES];
        logic [15:0] ip;
        sme_pkg::t_result expected_q[$];
        int errors;

        function new();
            depth = 0;
            ip = '0;
            errors = 0;
            foreach (mem[i]) mem[i] = 8'h00;
        endfunction

        function int pops(logic [sme_pkg::OP_W-1:0] op);
            case (op)
                sme_pkg::OP_DUMP, sme_pkg::OP_DUP, sme_pkg::OP_IF, sme_pkg::OP_DO,
                sme_pkg::OP_LOAD, sme_pkg::OP_DROP: return 1;
                sme_pkg::OP_SYS3: return 4;
                sme_pkg::OP_PUSH, sme_pkg::OP_ELSE, sme_pkg::OP_WHILE, sme_pkg::OP_END,
                sme_pkg::OP_MEM, sme_pkg::OP_SYS1: return 0;
                default: return 2;
            endcase
        endfunction

        function int pushes(logic [sme_pkg::OP_W-1:0] op);
            case (op)
                sme_pkg::OP_DUP, sme_pkg::OP_SWAP: return 2;
                sme_pkg::OP_OVER: return 3;
                sme_pkg::OP_DUP2: return 4;
                sme_pkg::OP_DUMP, sme_pkg::OP_IF, sme_pkg::OP_ELSE, sme_pkg::OP_WHILE,
                sme_pkg::OP_DO, sme_pkg::OP_END, sme_pkg::OP_STORE, sme_pkg::OP_SYS1,
                sme_pkg::OP_SYS3, sme_pkg::OP_DROP: return 0;
                default: return 1;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // executes one accepted instruction on the shadow state
        function void note_input(logic [sme_pkg::OP_W-1:0] op, logic [63:0] opd);
            sme_pkg::t_result r;
            logic [63:0] p [4];
            logic [63:0] w [4];
            logic [15:0] nxt;
            int np;
            int nr;
            r = '0;
            nxt = ip + 16'd1;
            foreach (w[i]) w[i] = '0;
            foreach (p[i]) p[i] = '0;
            np = 0;
            nr = 0;
            if (op > sme_pkg::OP_LAST) begin
                r.status = sme_pkg::ST_BAD_OP;
            end else begin
                np = pops(op);
                nr = pushes(op);
                if (depth < np) r.status = sme_pkg::ST_UNDERFLOW;
                else if (depth - np + nr > DEPTH) r.status = sme_pkg::ST_OVERFLOW;
            end
            if (r.status == sme_pkg::ST_OK) begin
                for (int i = 0; i < np; i++) p[i] = stk[depth - 1 - i];
                case (op)
                    sme_pkg::OP_PUSH: w[0] = opd;
                    sme_pkg::OP_PLUS: w[0] = p[1] + p[0];
                    sme_pkg::OP_MINUS: w[0] = p[1] - p[0];
                    sme_pkg::OP_EQ: w[0] = (p[1] == p[0]) ? 64'd1 : 64'd0;
                    sme_pkg::OP_DUMP: begin
                        r.print_valid = 1'b1;
                        r.print_value = p[0];
                    end
                    sme_pkg::OP_DUP: begin
                        w[0] = p[0];
                        w[1] = p[0];
                    end
                    sme_pkg::OP_GT: w[0] = ($signed(p[1]) > $signed(p[0])) ? 64'd1 : 64'd0;
                    sme_pkg::OP_LT: w[0] = ($signed(p[1]) < $signed(p[0])) ? 64'd1 : 64'd0;
                    sme_pkg::OP_IF, sme_pkg::OP_DO: if (p[0] == 64'd0) nxt = opd[15:0];
                    sme_pkg::OP_ELSE, sme_pkg::OP_END: nxt = opd[15:0];
                    sme_pkg::OP_MEM: w[0] = 64'd0;
                    sme_pkg::OP_LOAD: begin
                        if (p[0] >= MEM_BYTES) r.status = sme_pkg::ST_BAD_ADDR;
                        else w[0] = {56'd0, mem[p[0][11:0]]};
                    end
                    sme_pkg::OP_STORE: begin
                        if (p[1] >= MEM_BYTES) r.status = sme_pkg::ST_BAD_ADDR;
                        else mem[p[1][11:0]] = p[0][7:0];
                    end
                    sme_pkg::OP_SYS1: r.status = sme_pkg::ST_BAD_SYS;
                    sme_pkg::OP_SYS3: begin
                        if (p[0] != sme_pkg::SYS_WRITE) r.status = sme_pkg::ST_BAD_SYS;
                        else if (p[1] != sme_pkg::FD_STDOUT && p[1] != sme_pkg::FD_STDERR)
                            r.status = sme_pkg::ST_BAD_FD;
                        else if (p[2] >= MEM_BYTES || p[3] > MEM_BYTES - p[2])
                            r.status = sme_pkg::ST_BAD_ADDR;
                        else begin
                            r.write_valid = 1'b1;
                            r.write_channel = p[1][1:0];
                            r.write_address = p[2][11:0];
                            r.write_count = p[3][12:0];
                        end
                    end
                    sme_pkg::OP_DUP2: begin
                        w[0] = p[1];
                        w[1] = p[0];
                        w[2] = p[1];
                        w[3] = p[0];
                    end
                    sme_pkg::OP_SHR: w[0] = $signed(p[1]) >>> p[0][5:0];
                    sme_pkg::OP_SHL: w[0] = p[1] << p[0][5:0];
                    sme_pkg::OP_BOR: w[0] = p[1] | p[0];
                    sme_pkg::OP_BAND: w[0] = p[1] & p[0];
                    sme_pkg::OP_SWAP: begin
                        w[0] = p[0];
                        w[1] = p[1];
                    end
                    sme_pkg::OP_OVER: begin
                        w[0] = p[1];
                        w[1] = p[0];
                        w[2] = p[1];
                    end
                    default: ;
                endcase
            end
            if (r.status == sme_pkg::ST_OK) begin
                depth -= np;
                for (int i = 0; i < nr; i++) begin
                    stk[depth] = w[i];
                    depth++;
                end
                ip = nxt;
                r.next_address = nxt;
            end else begin
                r = '0;
                r.status = status_of_fault(op, np, nr, p);
                r.next_address = ip;
            end
            expected_q.push_back(r);
        endfunction

        // fault code recomputed after the record was cleared
        function logic [sme_pkg::STATUS_W-1:0] status_of_fault(logic [sme_pkg::OP_W-1:0] op,
                                                               int np, int nr,
                                                               logic [63:0] p [4]);
            if (op > sme_pkg::OP_LAST) return sme_pkg::ST_BAD_OP;
            if (depth < np) return sme_pkg::ST_UNDERFLOW;
            if (depth - np + nr > DEPTH) return sme_pkg::ST_OVERFLOW;
            if (op == sme_pkg::OP_SYS1) return sme_pkg::ST_BAD_SYS;
            if (op == sme_pkg::OP_SYS3 && p[0] != sme_pkg::SYS_WRITE) return sme_pkg::ST_BAD_SYS;
            if (op == sme_pkg::OP_SYS3 && p[1] != sme_pkg::FD_STDOUT &&
                p[1] != sme_pkg::FD_STDERR) return sme_pkg::ST_BAD_FD;
            return sme_pkg::ST_BAD_ADDR;
        endfunction

        task report(string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check(sme_pkg::t_result got);
            sme_pkg::t_result e;
            if (expected_q.size() == 0) begin
                report("result transfer with nothing expected");
                return;
            end
            e = expected_q.pop_front();
            if (got.status != e.status)
                report($sformatf("status %0d, expected %0d", got.status, e.status));
            if (got.next_address != e.next_address)
                report($sformatf("next_address %0h, expected %0h",
                                 got.next_address, e.next_address));
            if (got.print_valid != e.print_valid || got.print_value != e.print_value)
                report($sformatf("print %0b/%0h, expected %0b/%0h", got.print_valid,
                                 got.print_value, e.print_valid, e.print_value));
            if (got.write_valid != e.write_valid || got.write_channel != e.write_channel)
                report($sformatf("write %0b ch %0d, expected %0b ch %0d", got.write_valid,
                                 got.write_channel, e.write_valid, e.write_channel));
            if (got.write_address != e.write_address || got.write_count != e.write_count)
                report($sformatf("write %0h+%0d, expected %0h+%0d", got.write_address,
                                 got.write_count, e.write_address, e.write_count));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic [sme_pkg::OP_W-1:0] i_action = '0;
    logic signed [sme_pkg::WORD_W-1:0] i_operand = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    logic [sme_pkg::STATUS_W-1:0] o_status;
    logic [sme_pkg::NEXT_W-1:0] o_next_address;
    logic o_print_valid;
    logic signed [sme_pkg::WORD_W-1:0] o_print_value;
    logic o_write_valid;
    logic [sme_pkg::WCH_W-1:0] o_write_channel;
    logic [sme_pkg::WADDR_W-1:0] o_write_address;
    logic [sme_pkg::WCNT_W-1:0] o_write_count;

    exec_scoreboard sb = new();
    int gap_pct = 17;
    int stall_pct = 75;
    bit hold_req = 1'b0;
    int sent = 0;

    stack_machine_execute_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_action(i_action), .i_operand(i_operand),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_status(o_status), .o_next_address(o_next_address),
        .o_print_valid(o_print_valid), .o_print_value(o_print_value),
        .o_write_valid(o_write_valid), .o_write_channel(o_write_channel),
        .o_write_address(o_write_address), .o_write_count(o_write_count)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    task send(logic [sme_pkg::OP_W-1:0] op, logic [63:0] opd);
        i_in_valid <= 1'b1;
        i_action <= op;
        i_operand <= opd;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(op, opd);
        sent++;
        // each idle cycle is drawn on its own
        while ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    function logic [63:0] any_word();
        case ($urandom_range(0, 4))
            0: return {$urandom, $urandom};
            1: return 64'($urandom_range(0, 8));
            2: return -64'($urandom_range(1, 8));
            3: return $urandom_range(0, 1) ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h8000_0000_0000_0000;
            default: return 64'($urandom_range(0, 70));
        endcase
    endfunction

    function logic [63:0] mem_addr();
        case ($urandom_range(0, 9))
            0: return 64'(MEM_BYTES);
            1: return {$urandom, $urandom};
            2: return 64'(MEM_BYTES - 1);
            default: return 64'($urandom_range(0, 31));
        endcase
    endfunction

    task write_request();
        logic [63:0] buf_addr;
        buf_addr = mem_addr();
        send(sme_pkg::OP_PUSH,
             $urandom_range(0, 9) == 0 ? any_word() : 64'($urandom_range(0, 4096)));
        send(sme_pkg::OP_PUSH, buf_addr);
        send(sme_pkg::OP_PUSH,
             $urandom_range(0, 7) == 0 ? any_word() : 64'($urandom_range(1, 2)));
        send(sme_pkg::OP_PUSH,
             $urandom_range(0, 7) == 0 ? any_word() : sme_pkg::SYS_WRITE);
        send(sme_pkg::OP_SYS3, any_word());
    endtask

    task random_step();
        logic [sme_pkg::OP_W-1:0] op;
        case ($urandom_range(0, 19))
            0, 1: begin
                send(sme_pkg::OP_PUSH, mem_addr());
                send(sme_pkg::OP_PUSH, any_word());
                send(sme_pkg::OP_STORE, any_word());
            end
            2, 3: begin
                send(sme_pkg::OP_PUSH, mem_addr());
                send(sme_pkg::OP_LOAD, any_word());
            end
            4, 5: write_request();
            6: begin
                // fill the stack to the top, then overflow it
                while (sb.depth < DEPTH) send(sme_pkg::OP_PUSH, any_word());
                send($urandom_range(0, 1) ? sme_pkg::OP_PUSH : sme_pkg::OP_DUP2, any_word());
            end
            7: send(OP_UNDEF - 5'($urandom_range(0, 5)), any_word());
            8, 9, 10: send(sme_pkg::OP_PUSH, any_word());
            default: begin
                if (sb.depth > 48 && $urandom_range(0, 1)) op = sme_pkg::OP_DROP;
                else op = 5'($urandom_range(0, sme_pkg::OP_LAST));
                send(op, any_word());
            end
        endcase
    endtask

    // result side: checks transfers and drives the stall
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall)
                sb.check('{o_status, o_next_address, o_print_valid, o_print_value,
                           o_write_valid, o_write_channel, o_write_address, o_write_count});
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    initial begin
        int wait_cycles;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: faults on an empty machine, then each operation at the extremes
        send(sme_pkg::OP_DROP, '0);
        send(OP_UNDEF, '1);
        send(sme_pkg::OP_PUSH, 64'h7FFF_FFFF_FFFF_FFFF);
        send(sme_pkg::OP_PUSH, 64'd1);
        send(sme_pkg::OP_PLUS, '0);
        send(sme_pkg::OP_DUP, '0);
        send(sme_pkg::OP_PUSH, 64'h8000_0000_0000_0000);
        send(sme_pkg::OP_EQ, '0);
        send(sme_pkg::OP_PUSH, -64'd1);
        send(sme_pkg::OP_OVER, '0);
        send(sme_pkg::OP_GT, '0);
        send(sme_pkg::OP_SWAP, '0);
        send(sme_pkg::OP_LT, '0);
        send(sme_pkg::OP_PUSH, 64'd63);
        send(sme_pkg::OP_SHR, '0);
        send(sme_pkg::OP_PUSH, 64'd67);
        send(sme_pkg::OP_SHL, '0);
        send(sme_pkg::OP_DUP2, '0);
        send(sme_pkg::OP_BOR, '0);
        send(sme_pkg::OP_BAND, '0);
        send(sme_pkg::OP_DUMP, '0);
        send(sme_pkg::OP_MEM, '0);
        send(sme_pkg::OP_PUSH, 64'd255);
        send(sme_pkg::OP_STORE, '0);
        send(sme_pkg::OP_MEM, '0);
        send(sme_pkg::OP_LOAD, '0);
        send(sme_pkg::OP_IF, 64'hFFFF);
        send(sme_pkg::OP_PUSH, 64'd1);
        send(sme_pkg::OP_DO, 64'h1234);
        send(sme_pkg::OP_ELSE, 64'hFFFF_FFFF_FFFF_0007);
        send(sme_pkg::OP_WHILE, '0);
        send(sme_pkg::OP_END, 64'h0000_0000_0001_FFFF);
        send(sme_pkg::OP_SYS1, '0);
        write_request();

        while (sent < 1000) begin
            if (sent >= 333 && gap_pct == 17) begin
                gap_pct = 75;
                stall_pct = 17;
            end
            if (sent >= 666 && gap_pct == 75) begin
                gap_pct = 0;
                stall_pct = 0;
                hold_req = 1'b1;
            end
            random_step();
        end
        i_in_valid <= 1'b0;

        wait_cycles = 0;
        while (sb.pending() != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) $display("SUCCESS");
        else begin
            if (sb.pending() != 0) $display("%0d results never arrived", sb.pending());
            $display("FAILURE");
        end
        $finish;
    end
endmodule

@@ stack_machine_execute_unit.f @@
src/sme_pkg.sv
src/sme_alu.sv
src/stack_machine_execute_unit.sv
sim/stack_machine_execute_unit_test.sv
